>>> rtl/core/apg_pkg.sv
// Shared constants, types and the arctangent table of the arc point generator.
`default_nettype none

package apg_pkg;

    // Default signed width of a saturated coordinate.
    localparam int COORD_BITS_DEF = 32;

    // Widths of the stream payloads and of the fixed 32-bit fields.
    localparam int FIELD_W    = 32;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 160;

    // Angles are in 1/64 degree.
    localparam int ANGLE_W = 17;
    localparam int TURN_W  = 16;
    localparam logic [TURN_W-1:0] FULL_TURN    = 16'd23040;
    localparam logic [TURN_W-1:0] QUARTER_TURN = 16'd5760;
    localparam logic [TURN_W-1:0] HALF_TURN    = 16'd11520;
    localparam logic [TURN_W-1:0] THREE_QUARTER_TURN = 16'd17280;
    localparam logic signed [ANGLE_W-1:0] ANGLE_STEP = 17'sd320;

    // Residual angle in 1/64 degree to radians in Q2.30, scaled by 2^10.
    localparam int RESID_W = 13;
    localparam logic [28:0] RAD_SCALE = 29'd299845282;

    // CORDIC datapath in signed Q2.30 with headroom.
    localparam int TRIG_W = 34;
    localparam logic signed [TRIG_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;
    localparam int CORDIC_ITERS = 30;
    localparam int ITER_W = 5;

    // Points per arc: stepped points are limited to this, plus the closing finish point.
    localparam int POINT_CNT_W = 7;
    localparam logic [POINT_CNT_W-1:0] MAX_STEP_POINTS = 7'd72;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef enum logic [1:0] {
        CD_IDLE,
        CD_LOAD,
        CD_ITER,
        CD_DONE
    } cordic_state_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_POINT,
        SQ_TRIG,
        SQ_SCALE_X,
        SQ_WAIT_X,
        SQ_SCALE_Y,
        SQ_WAIT_Y,
        SQ_STORE
    } seq_state_t;

    // Control group from the sequencer to the shared scaling unit.
    typedef struct packed {
        logic start;
        logic sel_y;
    } scale_ctrl_t;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
        logic signed [TRIG_W-1:0] v;
        unique case (i)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            5'd24: v = 34'sd64;
            5'd25: v = 34'sd32;
            5'd26: v = 34'sd16;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/arc_point_generator.sv
// Top level of the arc point generator: arc sequencer, point pairing and output register.
//
// The block takes one arc per input transfer (center, signed radius, start and finish
// angle in 1/64 degree, z) and returns the points of a polyline along it, two points per
// output transfer. Points step by 5 degrees from the start angle, counterclockwise for a
// positive radius and clockwise for a negative one, and a point at the finish angle always
// closes the arc, so one arc gives 1 to 73 points in 1 to 37 output transfers; tlast marks
// the last of them and tuser says whether its second point is present. Points are made one
// at a time: the iterative CORDIC (a load state, 30 rotation steps and a done state) gives
// cosine and sine, and the single shared multiplier then scales them one after the other.
// The sequencer stalls while a finished transfer finds the output register still full. The
// block accepts no new arc until the last point of the current one has entered the output
// register; that register lets the next arc start while the final transfer still waits to
// be taken. Coordinates are saturated to a signed COORD_BITS range and returned in 32-bit
// fields.
`default_nettype none

module arc_point_generator
#(
    parameter int COORD_BITS = apg_pkg::COORD_BITS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // center_x[31:0], center_y[63:32], radius[95:64], angle_from[110:96],
    // angle_to[125:111], z_level[157:126], zero fill above.
    input  wire logic [apg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // first_x[31:0], first_y[63:32], second_x[95:64], second_y[127:96],
    // point_z[159:128].
    output logic [apg_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // second_valid[0].
    output logic                                   m_axis_tuser,
    // last_pair.
    output logic                                   m_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready
);

    localparam int FW = apg_pkg::FIELD_W;
    localparam int AW = apg_pkg::ANGLE_W;

    apg_pkg::seq_state_t state_reg;
    apg_pkg::seq_state_t state_next;

    // Arc parameters held for the whole arc, with the running step angle and point count.
    logic signed [FW-1:0]           cx_reg;
    logic signed [FW-1:0]           cy_reg;
    logic [FW-1:0]                  z_reg;
    logic [FW-1:0]                  mag_reg;
    logic                           cw_reg;
    logic signed [AW-1:0]           fi_reg;
    logic signed [AW-1:0]           t_reg;
    logic [apg_pkg::POINT_CNT_W-1:0] n_reg;

    // Current point and the held first point of a pair.
    logic                           final_reg;
    logic signed [apg_pkg::TRIG_W-1:0] cos_reg;
    logic signed [apg_pkg::TRIG_W-1:0] sin_reg;
    logic [FW-1:0]                  px_reg;
    logic [FW-1:0]                  py_reg;
    logic                           have_first_reg;
    logic [FW-1:0]                  hold_x_reg;
    logic [FW-1:0]                  hold_y_reg;

    // Output register.
    logic                           out_valid_reg;
    logic [FW-1:0]                  out_fx_reg;
    logic [FW-1:0]                  out_fy_reg;
    logic [FW-1:0]                  out_sx_reg;
    logic [FW-1:0]                  out_sy_reg;
    logic                           out_sv_reg;
    logic [FW-1:0]                  out_z_reg;
    logic                           out_last_reg;

    logic                           in_accept;
    logic                           out_free;
    logic                           out_load;
    logic                           step_more;
    logic [apg_pkg::TURN_W-1:0]     point_angle;
    logic signed [AW-1:0]           t_next;

    // Normalized angles of an incoming arc.
    logic [apg_pkg::TURN_W-1:0]     in_st_raw;
    logic [apg_pkg::TURN_W-1:0]     in_fi_raw;
    logic [apg_pkg::TURN_W-1:0]     in_st;
    logic [apg_pkg::TURN_W-1:0]     in_fi;
    logic [AW-1:0]                  in_fi_wrap;
    logic [AW-1:0]                  in_t0;
    logic signed [FW-1:0]           in_radius;

    logic                           cord_start;
    logic                           cord_done;
    logic signed [apg_pkg::TRIG_W-1:0] cord_cos;
    logic signed [apg_pkg::TRIG_W-1:0] cord_sin;

    apg_pkg::scale_ctrl_t           scale_ctrl;
    logic                           scale_done;
    logic [FW-1:0]                  scale_result;
    logic signed [apg_pkg::TRIG_W-1:0] scale_trig;
    logic signed [FW-1:0]           scale_center;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign in_radius = $signed(s_axis_tdata[95:64]);
    assign in_st_raw = {1'b0, s_axis_tdata[110:96]};
    assign in_fi_raw = {1'b0, s_axis_tdata[125:111]};

    // Fold angles of a full turn or more; finish at or after start; cw start up a turn.
    always_comb
    begin
        in_st = (in_st_raw >= apg_pkg::FULL_TURN) ? in_st_raw - apg_pkg::FULL_TURN
                                                   : in_st_raw;
        in_fi = (in_fi_raw >= apg_pkg::FULL_TURN) ? in_fi_raw - apg_pkg::FULL_TURN
                                                   : in_fi_raw;
        in_fi_wrap = (in_st > in_fi) ? AW'(in_fi) + AW'(apg_pkg::FULL_TURN) : AW'(in_fi);
        in_t0      = in_radius[FW-1] ? AW'(in_st) + AW'(apg_pkg::FULL_TURN) : AW'(in_st);
    end

    // Another stepped point follows until the finish or the step limit is reached.
    assign step_more = (n_reg < apg_pkg::MAX_STEP_POINTS)
                       && (cw_reg ? (t_reg > fi_reg) : (t_reg < fi_reg));
    assign point_angle = step_more ? t_reg[apg_pkg::TURN_W-1:0]
                                   : fi_reg[apg_pkg::TURN_W-1:0];
    assign t_next = cw_reg ? t_reg - apg_pkg::ANGLE_STEP : t_reg + apg_pkg::ANGLE_STEP;

    apg_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (point_angle),
        .done    (cord_done),
        .cos_val (cord_cos),
        .sin_val (cord_sin)
    );

    assign scale_trig   = scale_ctrl.sel_y ? sin_reg : cos_reg;
    assign scale_center = scale_ctrl.sel_y ? cy_reg : cx_reg;

    apg_scale #(
        .COORD_BITS (COORD_BITS)
    ) u_scale
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scale_ctrl.start),
        .mag    (mag_reg),
        .trig   (scale_trig),
        .center (scale_center),
        .done   (scale_done),
        .result (scale_result)
    );

    // Next state of the arc sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apg_pkg::SQ_IDLE:    if (s_axis_tvalid) state_next = apg_pkg::SQ_POINT;
            apg_pkg::SQ_POINT:   state_next = apg_pkg::SQ_TRIG;
            apg_pkg::SQ_TRIG:    if (cord_done) state_next = apg_pkg::SQ_SCALE_X;
            apg_pkg::SQ_SCALE_X: state_next = apg_pkg::SQ_WAIT_X;
            apg_pkg::SQ_WAIT_X:  if (scale_done) state_next = apg_pkg::SQ_SCALE_Y;
            apg_pkg::SQ_SCALE_Y: state_next = apg_pkg::SQ_WAIT_Y;
            apg_pkg::SQ_WAIT_Y:  if (scale_done) state_next = apg_pkg::SQ_STORE;
            apg_pkg::SQ_STORE:
            begin
                if (!final_reg && !have_first_reg)
                begin
                    state_next = apg_pkg::SQ_POINT;
                end
                else if (out_free)
                begin
                    state_next = final_reg ? apg_pkg::SQ_IDLE : apg_pkg::SQ_POINT;
                end
            end
            default:             state_next = apg_pkg::SQ_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_axis_tready    = (state_reg == apg_pkg::SQ_IDLE);
        cord_start       = (state_reg == apg_pkg::SQ_POINT);
        scale_ctrl.start = (state_reg == apg_pkg::SQ_SCALE_X)
                           || (state_reg == apg_pkg::SQ_SCALE_Y);
        scale_ctrl.sel_y = (state_reg == apg_pkg::SQ_SCALE_Y)
                           || (state_reg == apg_pkg::SQ_WAIT_Y);
        out_load         = (state_reg == apg_pkg::SQ_STORE)
                           && (final_reg || have_first_reg) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= apg_pkg::SQ_IDLE;
            have_first_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                have_first_reg <= 1'b0;
            end
            else if (state_reg == apg_pkg::SQ_STORE)
            begin
                if (!final_reg && !have_first_reg)
                begin
                    have_first_reg <= 1'b1;
                end
                else if (out_free)
                begin
                    have_first_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cx_reg  <= $signed(s_axis_tdata[31:0]);
            cy_reg  <= $signed(s_axis_tdata[63:32]);
            z_reg   <= s_axis_tdata[157:126];
            // Two's complement negate gives 2^31 exactly for the most negative radius.
            mag_reg <= in_radius[FW-1] ? (~in_radius[FW-1:0] + 1'b1) : in_radius[FW-1:0];
            cw_reg  <= in_radius[FW-1];
            fi_reg  <= $signed(in_fi_wrap);
            t_reg   <= $signed(in_t0);
            n_reg   <= '0;
        end
        if (state_reg == apg_pkg::SQ_POINT)
        begin
            final_reg <= !step_more;
        end
        if ((state_reg == apg_pkg::SQ_TRIG) && cord_done)
        begin
            cos_reg <= cord_cos;
            sin_reg <= cord_sin;
        end
        if ((state_reg == apg_pkg::SQ_WAIT_X) && scale_done)
        begin
            px_reg <= scale_result;
        end
        if ((state_reg == apg_pkg::SQ_WAIT_Y) && scale_done)
        begin
            py_reg <= scale_result;
        end
        if (state_reg == apg_pkg::SQ_STORE)
        begin
            if (!final_reg && (!have_first_reg || out_free))
            begin
                t_reg <= t_next;
                n_reg <= n_reg + 1'b1;
            end
            if (!final_reg && !have_first_reg)
            begin
                hold_x_reg <= px_reg;
                hold_y_reg <= py_reg;
            end
        end
        if (out_load)
        begin
            out_z_reg    <= z_reg;
            out_last_reg <= final_reg;
            if (have_first_reg)
            begin
                out_fx_reg <= hold_x_reg;
                out_fy_reg <= hold_y_reg;
                out_sx_reg <= px_reg;
                out_sy_reg <= py_reg;
                out_sv_reg <= 1'b1;
            end
            else
            begin
                out_fx_reg <= px_reg;
                out_fy_reg <= py_reg;
                out_sx_reg <= '0;
                out_sy_reg <= '0;
                out_sv_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_z_reg, out_sy_reg, out_sx_reg, out_fy_reg, out_fx_reg};
    assign m_axis_tuser  = out_sv_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/apg_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of an angle in 1/64 degree.
`default_nettype none

module apg_cordic
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [apg_pkg::TURN_W-1:0]          angle,
    output logic                                     done,
    output logic signed [apg_pkg::TRIG_W-1:0]        cos_val,
    output logic signed [apg_pkg::TRIG_W-1:0]        sin_val
);

    apg_pkg::cordic_state_t state_reg;
    apg_pkg::cordic_state_t state_next;

    apg_pkg::quad_t                      quad_reg;
    logic [apg_pkg::RESID_W-1:0]         resid_reg;
    logic [apg_pkg::ITER_W-1:0]          iter_reg;
    logic signed [apg_pkg::TRIG_W-1:0]   x_reg;
    logic signed [apg_pkg::TRIG_W-1:0]   y_reg;
    logic signed [apg_pkg::TRIG_W-1:0]   z_reg;

    logic [apg_pkg::TURN_W-1:0]          reduced;
    logic [apg_pkg::TURN_W-1:0]          resid_full;
    apg_pkg::quad_t                      quad_next;
    logic [41:0]                         z_prod;
    logic signed [apg_pkg::TRIG_W-1:0]   dx;
    logic signed [apg_pkg::TRIG_W-1:0]   dy;
    logic signed [apg_pkg::TRIG_W-1:0]   atan_i;
    logic                                last_iter;

    // Fold the angle into one turn and split off the quadrant.
    always_comb
    begin
        reduced = (angle >= apg_pkg::FULL_TURN) ? angle - apg_pkg::FULL_TURN : angle;
        priority if (reduced >= apg_pkg::THREE_QUARTER_TURN)
        begin
            quad_next  = apg_pkg::QUAD_3;
            resid_full = reduced - apg_pkg::THREE_QUARTER_TURN;
        end
        else if (reduced >= apg_pkg::HALF_TURN)
        begin
            quad_next  = apg_pkg::QUAD_2;
            resid_full = reduced - apg_pkg::HALF_TURN;
        end
        else if (reduced >= apg_pkg::QUARTER_TURN)
        begin
            quad_next  = apg_pkg::QUAD_1;
            resid_full = reduced - apg_pkg::QUARTER_TURN;
        end
        else
        begin
            quad_next  = apg_pkg::QUAD_0;
            resid_full = reduced;
        end
    end

    assign z_prod    = 42'(resid_reg) * 42'(apg_pkg::RAD_SCALE) + 42'd512;
    assign dx        = y_reg >>> iter_reg;
    assign dy        = x_reg >>> iter_reg;
    assign atan_i    = apg_pkg::atan_q30(iter_reg);
    assign last_iter = (iter_reg == apg_pkg::ITER_W'(apg_pkg::CORDIC_ITERS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apg_pkg::CD_IDLE: if (start) state_next = apg_pkg::CD_LOAD;
            apg_pkg::CD_LOAD: state_next = apg_pkg::CD_ITER;
            apg_pkg::CD_ITER: if (last_iter) state_next = apg_pkg::CD_DONE;
            apg_pkg::CD_DONE: state_next = apg_pkg::CD_IDLE;
            default:          state_next = apg_pkg::CD_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == apg_pkg::CD_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apg_pkg::CD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            apg_pkg::CD_IDLE:
            begin
                quad_reg  <= quad_next;
                resid_reg <= resid_full[apg_pkg::RESID_W-1:0];
            end
            apg_pkg::CD_LOAD:
            begin
                z_reg    <= $signed({2'b00, z_prod[41:10]});
                x_reg    <= apg_pkg::CORDIC_INV_GAIN;
                y_reg    <= '0;
                iter_reg <= '0;
            end
            apg_pkg::CD_ITER:
            begin
                if (!z_reg[apg_pkg::TRIG_W-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_i;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_i;
                end
                iter_reg <= iter_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Rotate the first-quadrant result into the quadrant of the angle.
    always_comb
    begin
        unique case (quad_reg)
            apg_pkg::QUAD_0:
            begin
                cos_val = x_reg;
                sin_val = y_reg;
            end
            apg_pkg::QUAD_1:
            begin
                cos_val = -y_reg;
                sin_val = x_reg;
            end
            apg_pkg::QUAD_2:
            begin
                cos_val = -x_reg;
                sin_val = -y_reg;
            end
            default:
            begin
                cos_val = y_reg;
                sin_val = -x_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/apg_scale.sv
// Shared multiply, round, offset and saturate unit for one coordinate.
`default_nettype none

module apg_scale
#(
    parameter int COORD_BITS = apg_pkg::COORD_BITS_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic [apg_pkg::FIELD_W-1:0]            mag,
    input  wire logic signed [apg_pkg::TRIG_W-1:0]      trig,
    input  wire logic signed [apg_pkg::FIELD_W-1:0]     center,
    output logic                                        done,
    output logic [apg_pkg::FIELD_W-1:0]                 result
);

    localparam int PROD_W = apg_pkg::FIELD_W + 1 + apg_pkg::TRIG_W;
    localparam int RES_W  = PROD_W - 30;
    localparam logic signed [64:0] SAT_HI = (65'sd1 <<< (COORD_BITS - 1)) - 65'sd1;
    localparam logic signed [64:0] SAT_LO = -SAT_HI - 65'sd1;

    logic                           prod_valid_reg;
    logic                           done_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [apg_pkg::FIELD_W-1:0] center_reg;
    logic [apg_pkg::FIELD_W-1:0]    result_reg;

    logic signed [PROD_W-1:0]       offset;
    logic signed [PROD_W-1:0]       sum;
    logic signed [RES_W-1:0]        rounded;
    logic signed [64:0]             wide;
    logic [apg_pkg::FIELD_W-1:0]    result_next;

    // Center shifted up by 30 with the rounding half folded in, so one add
    // gives floor((m*t + 2^29) / 2^30) + center.
    assign offset  = PROD_W'($signed({center_reg, 1'b1, 29'd0}));
    assign sum     = prod_reg + offset;
    assign rounded = sum[PROD_W-1:30];
    assign wide    = 65'(rounded);

    always_comb
    begin
        priority if (wide > SAT_HI)
        begin
            result_next = SAT_HI[apg_pkg::FIELD_W-1:0];
        end
        else if (wide < SAT_LO)
        begin
            result_next = SAT_LO[apg_pkg::FIELD_W-1:0];
        end
        else
        begin
            result_next = wide[apg_pkg::FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= start;
            done_reg       <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg   <= PROD_W'($signed({1'b0, mag})) * PROD_W'(trig);
            center_reg <= center;
        end
        if (prod_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the arc point generator: stream driver, predictor and monitor.
`timescale 1ns / 100ps

module tb_top;

    // Coordinate width of the instance under test, and the clamp limits that follow from it.
    localparam int     COORD_BITS = apg_pkg::COORD_BITS_DEF;
    localparam longint COORD_MAX  = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN  = -COORD_MAX - 1;

    // Angle constants as plain integers, so that the stepping arithmetic stays signed.
    localparam int TURN       = int'(apg_pkg::FULL_TURN);
    localparam int QUARTER    = int'(apg_pkg::QUARTER_TURN);
    localparam int STEP       = int'(apg_pkg::ANGLE_STEP);
    localparam int STEP_LIMIT = int'(apg_pkg::MAX_STEP_POINTS);
    localparam int MAX_PTS    = STEP_LIMIT + 1;

    // Percent of cycles in which either side holds off, and the window in which neither does.
    localparam int IDLE_PCT    = 7;
    localparam int QUIET_FROM  = 30000;
    localparam int QUIET_UNTIL = 110000;

    // Arctangent of 2^-i in Q2.30, one entry per CORDIC rotation.
    localparam longint ATAN_Q30 [0:29] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    // One arc as it travels on the input stream.
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] radius;
        logic [14:0]        angle_from;
        logic [14:0]        angle_to;
        logic signed [31:0] z_level;
    } arc_t;

    // One output transfer: a pair of polyline points.
    typedef struct {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic               second_valid;
        logic signed [31:0] point_z;
        logic               last_pair;
    } point_pair_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic [apg_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [apg_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;

    arc_t        arc_queue[$];      // arcs still to be offered to the block
    point_pair_t pending_pairs[$];  // predicted pairs, oldest first
    arc_t        arc_on_bus;        // the arc currently driven on the input stream
    point_pair_t got_pair;
    point_pair_t want_pair;
    int unsigned cycle_count = 0;
    int          mismatches = 0;
    int          pairs_seen = 0;
    logic        quiet;

    arc_point_generator #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Neither side idles inside this window, so back-to-back traffic is exercised too.
    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_UNTIL);

    // Cosine and sine in Q2.30 of an angle in 1/64 degree. The angle is folded into the
    // first quadrant, converted to radians, rotated by the CORDIC and then unfolded.
    function automatic void cordic_trig(input int angle, output longint cos_v,
                                        output longint sin_v);
        int     folded;
        int     quad;
        int     resid;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint rad_scale;
        folded    = angle % TURN;
        quad      = folded / QUARTER;
        resid     = folded % QUARTER;
        rad_scale = longint'(apg_pkg::RAD_SCALE);
        z = (longint'(resid) * rad_scale + 512) >>> 10;
        x = longint'(apg_pkg::CORDIC_INV_GAIN);
        y = 0;
        for (int i = 0; i < apg_pkg::CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_Q30[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_Q30[i];
            end
        end
        case (apg_pkg::quad_t'(quad[1:0]))
            apg_pkg::QUAD_0:
            begin
                cos_v = x;
                sin_v = y;
            end
            apg_pkg::QUAD_1:
            begin
                cos_v = -y;
                sin_v = x;
            end
            apg_pkg::QUAD_2:
            begin
                cos_v = -x;
                sin_v = -y;
            end
            default:
            begin
                cos_v = y;
                sin_v = -x;
            end
        endcase
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    // Scale a unit vector by the radius magnitude, round the Q8 x Q30 product to Q8,
    // add the center and clamp.
    function automatic longint place_coord(input longint mag, input longint trig_v,
                                           input longint center);
        return clamp_coord(((mag * trig_v + (longint'(1) <<< 29)) >>> 30) + center);
    endfunction

    // Works out every pair that one accepted arc must produce and appends them in order.
    function automatic void predict_arc_pairs(input arc_t a);
        longint      px[0:MAX_PTS-1];
        longint      py[0:MAX_PTS-1];
        longint      mag;
        longint      cos_v;
        longint      sin_v;
        int          st;
        int          fi;
        int          t;
        int          n;
        int          n_pairs;
        point_pair_t p;
        st = a.angle_from;
        fi = a.angle_to;
        // Angles at or beyond a full turn wrap to the same direction.
        if (st >= TURN)
            st = st - TURN;
        if (fi >= TURN)
            fi = fi - TURN;
        if (st > fi)
            fi = fi + TURN;
        mag = (a.radius < 0) ? -longint'(a.radius) : longint'(a.radius);
        n = 0;
        if (a.radius < 0)
        begin
            // Clockwise: start one turn up and walk down toward the finish.
            t = st + TURN;
            while (t > fi && n < STEP_LIMIT)
            begin
                cordic_trig(t, cos_v, sin_v);
                px[n] = place_coord(mag, cos_v, a.center_x);
                py[n] = place_coord(mag, sin_v, a.center_y);
                n++;
                t = t - STEP;
            end
        end
        else
        begin
            t = st;
            while (t < fi && n < STEP_LIMIT)
            begin
                cordic_trig(t, cos_v, sin_v);
                px[n] = place_coord(mag, cos_v, a.center_x);
                py[n] = place_coord(mag, sin_v, a.center_y);
                n++;
                t = t + STEP;
            end
        end
        // The finish point always closes the polyline.
        cordic_trig(fi, cos_v, sin_v);
        px[n] = place_coord(mag, cos_v, a.center_x);
        py[n] = place_coord(mag, sin_v, a.center_y);
        n++;
        n_pairs = (n + 1) / 2;
        for (int k = 0; k < n_pairs; k++)
        begin
            p.first_x = px[2*k][31:0];
            p.first_y = py[2*k][31:0];
            if (2*k + 1 < n)
            begin
                p.second_x     = px[2*k+1][31:0];
                p.second_y     = py[2*k+1][31:0];
                p.second_valid = 1'b1;
            end
            else
            begin
                p.second_x     = '0;
                p.second_y     = '0;
                p.second_valid = 1'b0;
            end
            p.point_z   = a.z_level;
            p.last_pair = (k == n_pairs - 1);
            pending_pairs.push_back(p);
        end
    endfunction

    // center_x is in the lowest bits; the two top bits are fill.
    function automatic logic [apg_pkg::IN_DATA_W-1:0] pack_arc(input arc_t a);
        return {2'b00, a.z_level, a.angle_to, a.angle_from, a.radius,
                a.center_y, a.center_x};
    endfunction

    task automatic add_arc(input logic signed [31:0] cx, input logic signed [31:0] cy,
                           input logic signed [31:0] r, input int st, input int fi,
                           input logic signed [31:0] z);
        arc_t a;
        a.center_x   = cx;
        a.center_y   = cy;
        a.radius     = r;
        a.angle_from = st[14:0];
        a.angle_to   = fi[14:0];
        a.z_level    = z;
        arc_queue.push_back(a);
    endtask

    // Random arcs: half are short arcs, which keep the run fast and produce many final
    // transfers; 30% use full-range fields so every bit and wrap is hit, 20% small radii.
    function automatic arc_t random_arc();
        arc_t a;
        int   kind;
        int   st;
        int   span;
        kind = $urandom_range(99);
        a.center_x = $urandom();
        a.center_y = $urandom();
        a.z_level  = $urandom();
        st = $urandom_range(TURN - 1);
        a.angle_from = st[14:0];
        if (kind < 50)
        begin
            span     = $urandom_range(1600);
            a.radius = $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            if (a.radius < 0)
                a.angle_to = 15'((st - span + TURN) % TURN);
            else
                a.angle_to = 15'((st + span) % TURN);
        end
        else if (kind < 80)
        begin
            a.angle_from = 15'($urandom_range(32767));
            a.angle_to   = 15'($urandom_range(32767));
            a.radius     = $urandom();
        end
        else
        begin
            a.angle_to = 15'($urandom_range(TURN - 1));
            a.radius   = $signed($urandom_range(2047)) - 1024;
            a.center_x = $signed($urandom_range(65535)) - 32768;
            a.center_y = $signed($urandom_range(65535)) - 32768;
        end
        return a;
    endfunction

    task automatic check_field(input string field, input longint want_v,
                               input longint got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s of output transfer %0d: expected %0d, got %0d",
                         $time, field, pairs_seen, want_v, got_v);
        end
    endtask

    // Input driver. A new arc is offered only once the previous one has been taken, and
    // the prediction for an arc is made at the edge where its transfer completes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_arc_pairs(arc_on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (arc_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    arc_on_bus = arc_queue.pop_front();
                    s_axis_tdata  <= pack_arc(arc_on_bus);
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. Ready is dropped at random; every completed transfer is checked
    // field by field against the oldest predicted pair.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_pair.first_x      = m_axis_tdata[31:0];
                got_pair.first_y      = m_axis_tdata[63:32];
                got_pair.second_x     = m_axis_tdata[95:64];
                got_pair.second_y     = m_axis_tdata[127:96];
                got_pair.point_z      = m_axis_tdata[159:128];
                got_pair.second_valid = m_axis_tuser;
                got_pair.last_pair    = m_axis_tlast;
                if (pending_pairs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: output transfer %0d arrived with none expected",
                                 $time, pairs_seen);
                end
                else
                begin
                    want_pair = pending_pairs.pop_front();
                    check_field("first_x", want_pair.first_x, got_pair.first_x);
                    check_field("first_y", want_pair.first_y, got_pair.first_y);
                    check_field("second_x", want_pair.second_x, got_pair.second_x);
                    check_field("second_y", want_pair.second_y, got_pair.second_y);
                    check_field("second_valid", want_pair.second_valid,
                                got_pair.second_valid);
                    check_field("point_z", want_pair.point_z, got_pair.point_z);
                    check_field("last_pair", want_pair.last_pair, got_pair.last_pair);
                end
                pairs_seen++;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        // Directed arcs first.
        // Zero radius with equal angles: a single point, so the second slot is empty.
        add_arc(32'sd25600, -32'sd12800, 32'sd0, 0, 0, 32'sd0);
        // A full counterclockwise turn: the step limit is reached, 37 transfers.
        add_arc(32'sd25600, 32'sd25600, 32'sd2560, 0, 23039, 32'sd256);
        // Start above finish, so the finish moves up one turn.
        add_arc(-32'sd1000, 32'sd1000, 32'sd65536, 23000, 100, -32'sd7);
        add_arc(32'sd0, 32'sd0, 32'sd1000, 1, 0, 32'sd1);
        // Clockwise arcs, two short and two with equal angles (a whole turn down).
        add_arc(32'sd0, 32'sd0, -32'sd2560, 100, 23000, 32'sd5);
        add_arc(32'sd3000, -32'sd3000, -32'sd1000000, 0, 0, 32'sd9);
        add_arc(32'sd0, 32'sd0, -32'sd70000, 17280, 17280, 32'sd3);
        add_arc(32'sd0, 32'sd0, -32'sd2560, 1000, 500, 32'sd0);
        // Most negative radius: its magnitude is used exactly.
        add_arc(32'sd0, 32'sd0, 32'h8000_0000, 5760, 5000, 32'sd0);
        // Saturation at both ends of the coordinate range.
        add_arc(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 5760, 32'sh7fff_ffff);
        add_arc(32'h8000_0000, 32'h8000_0000, 32'sh7fff_ffff, 11520, 17280,
                32'h8000_0000);
        // Angles of a full turn or more wrap to the same direction.
        add_arc(32'sd100, 32'sd200, 32'sd5000, 32767, 23040, 32'sd0);
        add_arc(32'sd100, 32'sd200, -32'sd5000, 23040, 32767, 32'sd0);
        // Quadrant boundaries and arcs that land exactly on a step.
        add_arc(32'sd0, 32'sd0, 32'sd256000, 5760, 6080, 32'sd0);
        add_arc(32'sd0, 32'sd0, 32'sd256000, 11520, 11520, 32'sd0);
        add_arc(32'sd0, 32'sd0, 32'sd256000, 0, 640, 32'sd0);
        add_arc(32'sd0, 32'sd0, 32'sd256000, 17279, 17281, -32'sd1);
        // Then random arcs.
        repeat (250)
            arc_queue.push_back(random_arc());

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every arc has been taken and every predicted pair has arrived.
        while (arc_queue.size() != 0 || s_axis_tvalid || pending_pairs.size() != 0)
            @(posedge clk);
        // Then keep running, so that any extra transfer is caught.
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit, so that a hung run still ends.
    initial
    begin
        #80_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/apg_pkg.sv
rtl/core/apg_cordic.sv
rtl/core/apg_scale.sv
rtl/core/arc_point_generator.sv
tb/tb_top.sv
